FILE: src/tbp_pkg.sv
// Package for the tagged buffer pool: status codes, widths, queue entry and FSM types.
// No dependencies.
`default_nettype none
package tbp_pkg;
	localparam int BUFFERS_DEF = 8;
	localparam int IDX_W       = 6;
	localparam int STAT_W      = 3;
	localparam int CNT_W       = 8;
	localparam int STAMP_W     = 32;

	typedef enum logic [STAT_W-1:0] {
		ST_HIT    = 3'd0,
		ST_NEW    = 3'd1,
		ST_NOFREE = 3'd2,
		ST_RANGE  = 3'd3,
		ST_OVER   = 3'd4,
		ST_FULL   = 3'd5
	} result_code_t;

	localparam logic OP_ACQ = 1'b0;
	localparam logic OP_REL = 1'b1;

	// request word as queued between front and back
	typedef struct packed {
		logic        op;
		logic [63:0] file_id;
		logic [31:0] attribute_id;
		logic [63:0] group_number;
		logic [7:0]  release_index;
	} req_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DONE
	} bk_state_t;
endpackage
`default_nettype wire

FILE: src/tbp_front.sv
// Front end of the tagged buffer pool: accepts request words into a two-entry queue.
// Depends on tbp_pkg.
`default_nettype none
module tbp_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire tbp_pkg::req_t in_req,
	output logic              q_valid,
	input  wire               q_ready,
	output tbp_pkg::req_t     q_req
);
	import tbp_pkg::*;

	req_t     mem_q [2];
	logic     wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic     push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

FILE: src/tbp_back.sv
// Back end of the tagged buffer pool: entry table, serial tag/victim scan, result register.
// Depends on tbp_pkg.
`default_nettype none
module tbp_back #(
	parameter int BUFFERS = tbp_pkg::BUFFERS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_valid,
	output logic                         q_ready,
	input  wire tbp_pkg::req_t           q_req,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [tbp_pkg::IDX_W-1:0]    out_index,
	output tbp_pkg::result_code_t        out_status,
	output logic                         out_fresh
);
	import tbp_pkg::*;

	localparam int EW = $clog2(BUFFERS);

	logic [BUFFERS-1:0] valid_q;
	logic [63:0]        tfile_q [BUFFERS];
	logic [31:0]        tattr_q [BUFFERS];
	logic [63:0]        tgrp_q  [BUFFERS];
	logic [CNT_W-1:0]   cnt_q   [BUFFERS];
	logic [STAMP_W-1:0] stamp_q [BUFFERS];
	logic [STAMP_W-1:0] clock_q;

	bk_state_t state_q, state_d;
	req_t      req_q;
	logic [EW-1:0] scan_q;
	logic      hit_q, found_q, inval_q;
	logic [EW-1:0] hit_e_q, pick_q;
	logic [STAMP_W-1:0] oldest_q;

	logic take, last, match, rel_ok;
	logic [EW-1:0] ridx;

	assign take   = (state_q == BK_IDLE) && q_valid;
	assign q_ready = (state_q == BK_IDLE);
	assign last   = ({{(32-EW){1'b0}}, scan_q} == BUFFERS - 1);
	assign match  = valid_q[scan_q] && tfile_q[scan_q] == req_q.file_id &&
		tattr_q[scan_q] == req_q.attribute_id && tgrp_q[scan_q] == req_q.group_number;
	assign rel_ok = ({24'd0, q_req.release_index} < BUFFERS);
	assign ridx   = q_req.release_index[EW-1:0];

	// victim choice including the last scanned entry
	function automatic logic [EW-1:0] vpick();
		if (found_q && inval_q) return pick_q;
		if (!valid_q[scan_q]) return scan_q;
		if (cnt_q[scan_q] == '0 && (!found_q || stamp_q[scan_q] < oldest_q)) return scan_q;
		return pick_q;
	endfunction

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (q_valid && q_req.op == OP_ACQ) state_d = BK_SCAN;
				else if (q_valid) state_d = BK_DONE;
			BK_SCAN: if (last) state_d = BK_DONE;
			BK_DONE: if (out_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	assign out_valid = (state_q == BK_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= '0;
			clock_q <= '0;
			for (int i = 0; i < BUFFERS; i++) begin
				cnt_q[i]   <= '0;
				stamp_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (take && q_req.op == OP_REL && rel_ok && cnt_q[ridx] != '0)
				cnt_q[ridx] <= cnt_q[ridx] - 8'd1;
			if (state_q == BK_SCAN && last) begin
				if (hit_q || match) begin
					if (cnt_q[hit_q ? hit_e_q : scan_q] != '1) begin
						cnt_q[hit_q ? hit_e_q : scan_q]   <= cnt_q[hit_q ? hit_e_q : scan_q] + 8'd1;
						stamp_q[hit_q ? hit_e_q : scan_q] <= clock_q;
						clock_q <= clock_q + 32'd1;
					end
				end else if (found_q || !valid_q[scan_q] ||
					cnt_q[scan_q] == '0) begin
					valid_q[vpick()] <= 1'b1;
					cnt_q[vpick()]   <= 8'd1;
					stamp_q[vpick()] <= clock_q;
					clock_q <= clock_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_q   <= q_req;
			scan_q  <= '0;
			hit_q   <= 1'b0;
			found_q <= 1'b0;
			inval_q <= 1'b0;
			out_fresh <= 1'b0;
			out_index <= q_req.release_index[IDX_W-1:0];
			if (!rel_ok) out_status <= ST_RANGE;
			else if (cnt_q[ridx] == '0) out_status <= ST_OVER;
			else out_status <= ST_HIT;
		end
		if (state_q == BK_SCAN) begin
			scan_q <= scan_q + EW'(1);
			if (!hit_q && match) begin
				hit_q <= 1'b1;
				hit_e_q <= scan_q;
			end
			if (!inval_q) begin
				if (!valid_q[scan_q]) begin
					inval_q <= 1'b1;
					found_q <= 1'b1;
					pick_q  <= scan_q;
				end else if (cnt_q[scan_q] == '0 && (!found_q || stamp_q[scan_q] < oldest_q)) begin
					found_q  <= 1'b1;
					pick_q   <= scan_q;
					oldest_q <= stamp_q[scan_q];
				end
			end
			if (last) begin
				out_fresh <= 1'b0;
				if (hit_q || match) begin
					out_index <= IDX_W'(hit_q ? hit_e_q : scan_q);
					out_status <= (cnt_q[hit_q ? hit_e_q : scan_q] == '1) ? ST_FULL : ST_HIT;
				end else if (found_q || !valid_q[scan_q] || cnt_q[scan_q] == '0) begin
					out_index  <= IDX_W'(vpick());
					out_status <= ST_NEW;
					out_fresh  <= 1'b1;
					tfile_q[vpick()] <= req_q.file_id;
					tattr_q[vpick()] <= req_q.attribute_id;
					tgrp_q[vpick()]  <= req_q.group_number;
				end else begin
					out_index  <= '0;
					out_status <= ST_NOFREE;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/tagged_buffer_pool_lru.sv
// Tagged buffer pool with LRU replacement, reference-counted entries.
// Acquire: a serial scan from accept to result (one entry compared per scan cycle).
// Release: answered without a scan. One request in the back end at a time; the two-word input
// queue keeps accepting while a result waits. Reset (arst_n low, async) clears
// valid bits, holder counts, stamps and the use clock; tags are left unset.
`default_nettype none
module tagged_buffer_pool_lru #(
	parameter int BUFFERS = tbp_pkg::BUFFERS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [167:0] s_tdata,  // file_id[63:0], attribute_id[95:64], group_number[159:96], release_index[167:160]
	input  wire          s_tuser,  // op
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [15:0]  m_tdata,  // entry_index[5:0], status[8:6], fresh[9], zero fill
	output logic [1:0]   m_tuser   // unused fill, always zero
);
	import tbp_pkg::*;

	req_t   in_req, q_req;
	logic   q_valid, q_ready;
	logic [IDX_W-1:0] idx;
	result_code_t st;
	logic fr;

	assign in_req.op            = s_tuser;
	assign in_req.file_id       = s_tdata[63:0];
	assign in_req.attribute_id  = s_tdata[95:64];
	assign in_req.group_number  = s_tdata[159:96];
	assign in_req.release_index = s_tdata[167:160];

	tbp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	tbp_back #(.BUFFERS(BUFFERS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_index(idx), .out_status(st), .out_fresh(fr)
	);

	assign m_tdata = {6'd0, fr, st, idx};
	assign m_tuser = 2'd0;

`ifndef SYNTHESIS
	// fresh only comes with a newly assigned entry
	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[8:6] == ST_NEW)
		else $error("fresh without new status");
	// a pending result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire
